[hw/rtl/assert_macros.svh]
// assertion macros used by svpwm_sector_duty_calc
// no dependencies; expects a clock and an active-low reset at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLKD(label, clk, rst_n, !(cond), msg)

`endif

[hw/rtl/svpwm_pkg.sv]
// types, constants and helpers for the svpwm sector/duty calculator
// no dependencies
`timescale 1ns / 1ps

package svpwm_pkg;

    // wide signed width for the scaled alpha/beta terms
    localparam int WIDE_W      = 36;
    localparam int PROD_W      = 33;
    localparam int DUTY_SHIFT  = 18;   // (x / 2) / 131072
    localparam int QUOT_SHIFT  = 17;   // x / 131072
    localparam int PIPE_DEPTH  = 6;

    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    localparam logic [13:0] PWM_PERIOD_RST     = 14'd1800;
    localparam logic [15:0] PERIOD_SQRT3_RST   = 16'd12470;
    localparam logic [15:0] WINDOW_AFTER_RST   = 16'd100;
    localparam logic [15:0] WINDOW_BEFORE_RST  = 16'd60;
    localparam logic [15:0] WINDOW_DELTA_RST   = 16'd160;
    localparam logic [15:0] WINDOW_HALF_RST    = 16'd80;
    localparam logic [15:0] TEST_OFFSET_RST    = 16'd10;
    localparam logic        TRIGGER_MODE_RST   = 1'b0;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_PWM_PERIOD    = 3'd0;
    localparam logic [2:0] REG_PERIOD_SQRT3  = 3'd1;
    localparam logic [2:0] REG_WINDOW_AFTER  = 3'd2;
    localparam logic [2:0] REG_WINDOW_BEFORE = 3'd3;
    localparam logic [2:0] REG_WINDOW_DELTA  = 3'd4;
    localparam logic [2:0] REG_WINDOW_HALF   = 3'd5;
    localparam logic [2:0] REG_TEST_OFFSET   = 3'd6;
    localparam logic [2:0] REG_TRIGGER_MODE  = 3'd7;

    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;
    localparam logic [2:0] SEC_6 = 3'd6;

    localparam logic TRIG_FIXED    = 1'b0;

    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
    } svpwm_vec_t;

    typedef struct packed {
        logic [2:0]  sector;
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [15:0] trigger_compare;
        logic        trigger_falling;
    } svpwm_result_t;

    // signed divide by 2**sh, rounding toward zero
    function automatic logic signed [WIDE_W-1:0] div_pow2_trunc(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              sh
    );
        logic signed [WIDE_W-1:0] bias;
        bias = v[WIDE_W-1] ? signed'((WIDE_W'(1) << sh) - WIDE_W'(1)) : '0;
        return (v + bias) >>> sh;
    endfunction

endpackage

[hw/rtl/svpwm_sector_duty_calc.sv]
// svpwm sector/duty calculator: each accepted transaction leaves the output
// register with the done strobe; one transaction accepted every cycle, busy stays low
// six register stages: multiply, x/y/z and sector, quotients, duties,
// trigger operands, trigger placement and output register
// reset clears the valid pipeline and loads the register defaults
// depends on svpwm_pkg and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module svpwm_sector_duty_calc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  svpwm_pkg::svpwm_vec_t               vec,
    output logic                                done,
    output svpwm_pkg::svpwm_result_t            result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [svpwm_pkg::PADDR_W-1:0]       paddr,
    input  logic [svpwm_pkg::PDATA_W-1:0]       pwdata,
    output logic [svpwm_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import svpwm_pkg::*;

    // ---------------- configuration registers ----------------
    logic [13:0] pwm_period_reg;
    logic [15:0] period_sqrt3_reg;
    logic [15:0] window_after_reg;
    logic [15:0] window_before_reg;
    logic [15:0] window_delta_reg;
    logic [15:0] window_half_reg;
    logic [15:0] test_offset_reg;
    logic        trigger_mode_reg;

    logic        cfg_write;
    logic [2:0]  cfg_index;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg    <= PWM_PERIOD_RST;
            period_sqrt3_reg  <= PERIOD_SQRT3_RST;
            window_after_reg  <= WINDOW_AFTER_RST;
            window_before_reg <= WINDOW_BEFORE_RST;
            window_delta_reg  <= WINDOW_DELTA_RST;
            window_half_reg   <= WINDOW_HALF_RST;
            test_offset_reg   <= TEST_OFFSET_RST;
            trigger_mode_reg  <= TRIGGER_MODE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PWM_PERIOD:    pwm_period_reg    <= pwdata[13:0];
                REG_PERIOD_SQRT3:  period_sqrt3_reg  <= pwdata[15:0];
                REG_WINDOW_AFTER:  window_after_reg  <= pwdata[15:0];
                REG_WINDOW_BEFORE: window_before_reg <= pwdata[15:0];
                REG_WINDOW_DELTA:  window_delta_reg  <= pwdata[15:0];
                REG_WINDOW_HALF:   window_half_reg   <= pwdata[15:0];
                REG_TEST_OFFSET:   test_offset_reg   <= pwdata[15:0];
                REG_TRIGGER_MODE:  trigger_mode_reg  <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_PWM_PERIOD:    prdata = PDATA_W'(pwm_period_reg);
            REG_PERIOD_SQRT3:  prdata = PDATA_W'(period_sqrt3_reg);
            REG_WINDOW_AFTER:  prdata = PDATA_W'(window_after_reg);
            REG_WINDOW_BEFORE: prdata = PDATA_W'(window_before_reg);
            REG_WINDOW_DELTA:  prdata = PDATA_W'(window_delta_reg);
            REG_WINDOW_HALF:   prdata = PDATA_W'(window_half_reg);
            REG_TEST_OFFSET:   prdata = PDATA_W'(test_offset_reg);
            REG_TRIGGER_MODE:  prdata = PDATA_W'(trigger_mode_reg);
        endcase
    end

    logic [15:0] period16;
    logic [15:0] tt16;
    assign period16 = {2'b00, pwm_period_reg};
    assign tt16     = {pwm_period_reg, 2'b00};

    // ---------------- valid pipeline ----------------
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end
    assign done = valid_reg[PIPE_DEPTH-1];

    // ---------------- stage 1: products ----------------
    logic signed [PROD_W-1:0] s1_alpha_reg, s1_alpha_next;
    logic signed [PROD_W-1:0] s1_prod_b_reg, s1_prod_b_next;

    assign s1_alpha_next  = $signed(vec.v_alpha) * $signed({1'b0, period_sqrt3_reg});
    assign s1_prod_b_next = $signed(vec.v_beta) * $signed({1'b0, tt16});

    always_ff @(posedge clk)
    begin
        s1_alpha_reg  <= s1_alpha_next;
        s1_prod_b_reg <= s1_prod_b_next;
    end

    // ---------------- stage 2: x, y, z and sector ----------------
    logic signed [WIDE_W-1:0] beta_w, alpha_w;
    logic signed [WIDE_W-1:0] s2_x_reg, s2_x_next;
    logic signed [WIDE_W-1:0] s2_y_reg, s2_y_next;
    logic signed [WIDE_W-1:0] s2_z_reg, s2_z_next;
    logic [2:0]               s2_sector_reg, s2_sector_next;

    always_comb
    begin
        alpha_w   = WIDE_W'(s1_alpha_reg);
        beta_w    = -WIDE_W'(s1_prod_b_reg);
        s2_x_next = beta_w;
        s2_y_next = div_pow2_trunc(beta_w + alpha_w, 1);
        s2_z_next = div_pow2_trunc(beta_w - alpha_w, 1);
        if (s2_y_next[WIDE_W-1])
        begin
            if (s2_z_next[WIDE_W-1])
                s2_sector_next = SEC_5;
            else if (s2_x_next[WIDE_W-1] || (s2_x_next == '0))
                s2_sector_next = SEC_4;
            else
                s2_sector_next = SEC_3;
        end
        else
        begin
            if (!s2_z_next[WIDE_W-1])
                s2_sector_next = SEC_2;
            else if (s2_x_next[WIDE_W-1] || (s2_x_next == '0))
                s2_sector_next = SEC_6;
            else
                s2_sector_next = SEC_1;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_x_reg      <= s2_x_next;
        s2_y_reg      <= s2_y_next;
        s2_z_reg      <= s2_z_next;
        s2_sector_reg <= s2_sector_next;
    end

    // ---------------- stage 3: scaled quotients ----------------
    logic signed [WIDE_W-1:0] tt_w, term_sum;
    logic signed [WIDE_W-1:0] term_q, qx_w, qy_w, qz_w;
    logic [15:0] s3_term_reg, s3_term_next;
    logic [15:0] s3_qx_reg, s3_qx_next;
    logic [15:0] s3_qy_reg, s3_qy_next;
    logic [15:0] s3_qz_reg, s3_qz_next;
    logic [2:0]  s3_sector_reg;

    always_comb
    begin
        tt_w = signed'(WIDE_W'(tt16));
        unique case (s2_sector_reg)
            SEC_1, SEC_4: term_sum = tt_w + s2_x_reg - s2_z_reg;
            SEC_2, SEC_5: term_sum = tt_w + s2_y_reg - s2_z_reg;
            default:      term_sum = tt_w - s2_x_reg + s2_y_reg;
        endcase
        term_q       = div_pow2_trunc(term_sum, DUTY_SHIFT);
        qx_w         = div_pow2_trunc(s2_x_reg, QUOT_SHIFT);
        qy_w         = div_pow2_trunc(s2_y_reg, QUOT_SHIFT);
        qz_w         = div_pow2_trunc(s2_z_reg, QUOT_SHIFT);
        s3_term_next = term_q[15:0];
        s3_qx_next   = qx_w[15:0];
        s3_qy_next   = qy_w[15:0];
        s3_qz_next   = qz_w[15:0];
    end

    always_ff @(posedge clk)
    begin
        s3_term_reg   <= s3_term_next;
        s3_qx_reg     <= s3_qx_next;
        s3_qy_reg     <= s3_qy_next;
        s3_qz_reg     <= s3_qz_next;
        s3_sector_reg <= s2_sector_reg;
    end

    // ---------------- stage 4: phase compare values ----------------
    logic [15:0] s4_a_reg, s4_a_next;
    logic [15:0] s4_b_reg, s4_b_next;
    logic [15:0] s4_c_reg, s4_c_next;
    logic [2:0]  s4_sector_reg;

    always_comb
    begin
        s4_a_next = {3'b000, pwm_period_reg[13:1]} + s3_term_reg;
        unique case (s3_sector_reg)
            SEC_1, SEC_4:
            begin
                s4_b_next = s4_a_next + s3_qz_reg;
                s4_c_next = s4_b_next - s3_qx_reg;
            end
            SEC_2, SEC_5:
            begin
                s4_b_next = s4_a_next + s3_qz_reg;
                s4_c_next = s4_a_next - s3_qy_reg;
            end
            default:
            begin
                s4_c_next = s4_a_next - s3_qy_reg;
                s4_b_next = s4_c_next + s3_qx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s4_a_reg      <= s4_a_next;
        s4_b_reg      <= s4_b_next;
        s4_c_reg      <= s4_c_next;
        s4_sector_reg <= s3_sector_reg;
    end

    // ---------------- stage 5: trigger operands ----------------
    logic [15:0] edge_ph, other_ph;
    logic [15:0] s5_room_reg, s5_room_next;
    logic [15:0] s5_diff_reg, s5_diff_next;
    logic [15:0] s5_early_reg, s5_early_next;
    logic [15:0] s5_late_reg, s5_late_next;
    logic [15:0] s5_a_reg, s5_b_reg, s5_c_reg;
    logic [2:0]  s5_sector_reg;

    always_comb
    begin
        // sampled phase edge and the phase it is measured against
        unique case (s4_sector_reg)
            SEC_1:   begin edge_ph = s4_a_reg; other_ph = s4_b_reg; end
            SEC_2:   begin edge_ph = s4_b_reg; other_ph = s4_a_reg; end
            SEC_3:   begin edge_ph = s4_b_reg; other_ph = s4_c_reg; end
            SEC_4:   begin edge_ph = s4_c_reg; other_ph = s4_b_reg; end
            SEC_5:   begin edge_ph = s4_c_reg; other_ph = s4_a_reg; end
            default: begin edge_ph = s4_a_reg; other_ph = s4_c_reg; end
        endcase
        s5_room_next  = period16 - edge_ph;
        s5_diff_next  = edge_ph - other_ph;
        s5_early_next = edge_ph - window_before_reg;
        s5_late_next  = edge_ph + window_after_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_room_reg   <= s5_room_next;
        s5_diff_reg   <= s5_diff_next;
        s5_early_reg  <= s5_early_next;
        s5_late_reg   <= s5_late_next;
        s5_a_reg      <= s4_a_reg;
        s5_b_reg      <= s4_b_reg;
        s5_c_reg      <= s4_c_reg;
        s5_sector_reg <= s4_sector_reg;
    end

    // ---------------- stage 6: trigger placement, output register ----------------
    logic [15:0]   trig_calc;
    logic          fall_calc;
    logic [15:0]   reflect;
    svpwm_result_t result_reg, result_next;

    always_comb
    begin
        reflect   = {pwm_period_reg, 1'b0} - s5_late_reg - 16'd1;
        trig_calc = period16 - 16'd1;
        fall_calc = 1'b0;
        priority if (s5_room_reg > window_after_reg)
        begin
            trig_calc = period16 - 16'd1;
        end
        else if (s5_diff_reg > window_delta_reg)
        begin
            trig_calc = s5_early_reg;
        end
        else if (s5_room_reg > window_half_reg)
        begin
            // sample after the edge, folded onto the falling slope past the period
            if (s5_late_reg >= period16)
            begin
                trig_calc = reflect;
                fall_calc = 1'b1;
            end
            else
            begin
                trig_calc = s5_late_reg;
            end
        end
        else
        begin
            trig_calc = period16 - 16'd1;
        end

        result_next.sector = s5_sector_reg;
        result_next.duty_a = s5_a_reg;
        result_next.duty_b = s5_b_reg;
        result_next.duty_c = s5_c_reg;
        if (trigger_mode_reg == TRIG_FIXED)
        begin
            result_next.trigger_compare = period16 - test_offset_reg;
            result_next.trigger_falling = 1'b0;
        end
        else
        begin
            result_next.trigger_compare = trig_calc;
            result_next.trigger_falling = fall_calc;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end
    assign result = result_reg;

    // ---------------- assertions ----------------
    `ASSERT_CLKD(a_accept_to_done, clk, rst_n,
        (start && !busy) |-> ##6 done, "accepted transaction did not complete in 6 cycles")
    `ASSERT_CLKD(a_done_has_source, clk, rst_n,
        done |-> $past(start && !busy, 6), "done strobe without an accepted transaction")
    `ASSERT_NEVER(a_sector_range, clk, rst_n,
        done && (result.sector == 3'd0 || result.sector == 3'd7), "sector out of range")
    `ASSERT_CLKD(a_fixed_no_fall, clk, rst_n,
        (done && ($past(trigger_mode_reg) == TRIG_FIXED)) |-> !result.trigger_falling,
        "falling flag set in fixed trigger mode")

endmodule
